FILE: rtl/dkc_pkg.sv
// Package: constants, codes and control structs for the relaxed canonicalizer.
`timescale 1ns / 1ps
package dkc_pkg;

  localparam int MAX_PENDING_LINES = 16;
  localparam int NAME_SPACE_DEPTH  = 8;

  localparam int PL_W   = $clog2(MAX_PENDING_LINES + 1);
  localparam int NS_W   = $clog2(NAME_SPACE_DEPTH + 1);
  localparam int TAIL_N = 3;
  localparam int TAIL_W = 2;

  localparam logic [1:0] REQ_HDR_BYTE  = 2'd0;
  localparam logic [1:0] REQ_BODY_BYTE = 2'd1;
  localparam logic [1:0] REQ_END_FIELD = 2'd2;
  localparam logic [1:0] REQ_END_BODY  = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic plan_nonempty;
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

FILE: rtl/dkc_if.sv
// Interfaces: input request channel and canonical output byte channel.
`timescale 1ns / 1ps
interface dkc_in_if import dkc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       append_crlf;

  modport source (output valid, output req_type, output data_byte, output append_crlf,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input append_crlf,
                  output ready);
endinterface

interface dkc_out_if import dkc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_byte, output last, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input overflow,
                  output ready);
endinterface

FILE: rtl/dkim_relaxed_canonicalizer_core.sv
// Top level: DKIM relaxed canonicalizer, controller plus datapath.
// The request loads the emission plan registers; an emission step then moves the first
// byte into the output register. The input is not ready while a request's bytes are
// being emitted; the emission sequencer moves one byte a cycle while the output register
// is free, and output stalls hold it.
// Reset: synchronous active-low rst_n clears all canonicalization state and flags.
`timescale 1ns / 1ps
module dkim_relaxed_canonicalizer_core import dkc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dkc_in_if.sink    in_chan,
  dkc_out_if.source out_chan
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     ready;

  assign in_chan.ready = ready;

  dkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dkc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (in_chan.req_type),
    .data_byte   (in_chan.data_byte),
    .append_crlf (in_chan.append_crlf),
    .out_chan    (out_chan)
  );

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !ready)
    else $error("input ready while emitting");

  a_busy_after_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && ready && sts.plan_nonempty) |=> !ready)
    else $error("input ready right after request with output");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last) |=> ready)
    else $error("controller not idle after last byte");

  a_valid_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.step))
    else $error("output valid without an emission step");

endmodule

FILE: rtl/dkc_ctrl.sv
// Controller: accepts a request, then sequences the emission of its output bytes.
`timescale 1ns / 1ps
module dkc_ctrl import dkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && sts.plan_nonempty) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = sts.out_free;
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/dkc_datapath.sv
// Datapath: canonicalization state, per-request emission plan and output register.
`timescale 1ns / 1ps
module dkc_datapath import dkc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_cmd_t        cmd,
  output dp_sts_t         sts,
  input  logic [1:0]      req_type,
  input  logic [7:0]      data_byte,
  input  logic            append_crlf,
  dkc_out_if.source       out_chan
);

  // canonicalization state
  logic                        in_value_r, in_value_nxt;
  logic                        started_r, started_nxt;
  logic                        vsp_r, vsp_nxt;
  logic [NS_W-1:0]             ns_cnt_r, ns_cnt_nxt;
  logic [NAME_SPACE_DEPTH-1:0] ns_kinds_r, ns_kinds_nxt;
  logic                        bsp_r, bsp_nxt;
  logic [PL_W-1:0]             pl_r, pl_nxt;
  logic                        content_r, content_nxt;
  logic                        ovf_r, ovf_nxt;

  // plan for the accepted request
  logic [NS_W-1:0]             p_ns_cnt;
  logic [NAME_SPACE_DEPTH-1:0] p_ns_kinds;
  logic [PL_W-1:0]             p_pl;
  logic                        p_sp;
  logic [TAIL_W-1:0]           p_tail_n;
  logic [TAIL_N*8-1:0]         p_tail;
  logic                        p_ovf;

  // plan being emitted
  logic [NS_W-1:0]             em_ns_cnt_r, em_ns_cnt_nxt;
  logic [NAME_SPACE_DEPTH-1:0] em_kinds_r, em_kinds_nxt;
  logic [PL_W-1:0]             em_pl_r, em_pl_nxt;
  logic                        em_lf_r, em_lf_nxt;
  logic                        em_sp_r, em_sp_nxt;
  logic [TAIL_W-1:0]           em_tail_n_r, em_tail_n_nxt;
  logic [TAIL_N*8-1:0]         em_tail_r, em_tail_nxt;
  logic                        em_ovf_r;
  logic [7:0]                  em_byte;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;

  logic [7:0] c;
  logic       c_blank;

  assign c       = data_byte;
  assign c_blank = (c == CH_SP) || (c == CH_TAB);

  always_comb begin
    in_value_nxt = in_value_r;
    started_nxt  = started_r;
    vsp_nxt      = vsp_r;
    ns_cnt_nxt   = ns_cnt_r;
    ns_kinds_nxt = ns_kinds_r;
    bsp_nxt      = bsp_r;
    pl_nxt       = pl_r;
    content_nxt  = content_r;
    ovf_nxt      = ovf_r;
    p_ns_cnt     = '0;
    p_ns_kinds   = '0;
    p_pl         = '0;
    p_sp         = 1'b0;
    p_tail_n     = '0;
    p_tail       = '0;
    unique case (req_type)
      REQ_HDR_BYTE: begin
        if (!in_value_r) begin
          if (c == CH_COLON) begin
            ns_cnt_nxt   = '0;
            ns_kinds_nxt = '0;
            in_value_nxt = 1'b1;
            p_tail       = {16'h0, CH_COLON};
            p_tail_n     = TAIL_W'(1);
          end else if (c_blank) begin
            if (ns_cnt_r < NS_W'(NAME_SPACE_DEPTH)) begin
              ns_kinds_nxt = ns_kinds_r |
                             (NAME_SPACE_DEPTH'(c == CH_TAB) << ns_cnt_r);
              ns_cnt_nxt   = ns_cnt_r + NS_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            p_ns_cnt     = ns_cnt_r;
            p_ns_kinds   = ns_kinds_r;
            ns_cnt_nxt   = '0;
            ns_kinds_nxt = '0;
            p_tail_n     = TAIL_W'(1);
            if (c >= CH_UP_A && c <= CH_UP_Z) p_tail = {16'h0, c | CH_CASE};
            else                              p_tail = {16'h0, c};
          end
        end else if (c == CH_CR || c == CH_LF) begin
          p_tail_n = '0;
        end else if (c_blank) begin
          vsp_nxt = 1'b1;
        end else begin
          p_sp        = vsp_r && started_r;
          vsp_nxt     = 1'b0;
          started_nxt = 1'b1;
          p_tail      = {16'h0, c};
          p_tail_n    = TAIL_W'(1);
        end
      end
      REQ_BODY_BYTE: begin
        if (c == CH_CR) begin
          p_tail_n = '0;
        end else if (c == CH_LF) begin
          bsp_nxt = 1'b0;
          if (pl_r < PL_W'(MAX_PENDING_LINES)) pl_nxt = pl_r + PL_W'(1);
          else                                 ovf_nxt = 1'b1;
        end else if (c_blank) begin
          bsp_nxt = 1'b1;
        end else begin
          p_pl        = pl_r;
          pl_nxt      = '0;
          p_sp        = bsp_r;
          bsp_nxt     = 1'b0;
          p_tail      = {16'h0, c};
          p_tail_n    = TAIL_W'(1);
          content_nxt = 1'b1;
        end
      end
      REQ_END_FIELD: begin
        if (!in_value_r) begin
          p_tail   = {CH_LF, CH_CR, CH_COLON};
          p_tail_n = append_crlf ? TAIL_W'(3) : TAIL_W'(1);
        end else begin
          p_tail   = {8'h0, CH_LF, CH_CR};
          p_tail_n = append_crlf ? TAIL_W'(2) : TAIL_W'(0);
        end
        in_value_nxt = 1'b0;
        started_nxt  = 1'b0;
        vsp_nxt      = 1'b0;
        ns_cnt_nxt   = '0;
        ns_kinds_nxt = '0;
      end
      REQ_END_BODY: begin
        p_tail      = {8'h0, CH_LF, CH_CR};
        p_tail_n    = content_r ? TAIL_W'(2) : TAIL_W'(0);
        bsp_nxt     = 1'b0;
        pl_nxt      = '0;
        content_nxt = 1'b0;
        ovf_nxt     = 1'b0;
      end
      default: p_tail_n = '0;
    endcase
    p_ovf = (req_type == REQ_END_BODY) ? ovf_r : ovf_nxt;
  end

  // next byte of the plan, in order: name blanks, deferred lines, space, tail
  always_comb begin
    em_ns_cnt_nxt = em_ns_cnt_r;
    em_kinds_nxt  = em_kinds_r;
    em_pl_nxt     = em_pl_r;
    em_lf_nxt     = em_lf_r;
    em_sp_nxt     = em_sp_r;
    em_tail_n_nxt = em_tail_n_r;
    em_tail_nxt   = em_tail_r;
    em_byte       = em_tail_r[7:0];
    priority if (em_ns_cnt_r != '0) begin
      em_byte       = em_kinds_r[0] ? CH_TAB : CH_SP;
      em_kinds_nxt  = em_kinds_r >> 1;
      em_ns_cnt_nxt = em_ns_cnt_r - NS_W'(1);
    end else if (em_pl_r != '0) begin
      if (!em_lf_r) begin
        em_byte   = CH_CR;
        em_lf_nxt = 1'b1;
      end else begin
        em_byte   = CH_LF;
        em_lf_nxt = 1'b0;
        em_pl_nxt = em_pl_r - PL_W'(1);
      end
    end else if (em_sp_r) begin
      em_byte   = CH_SP;
      em_sp_nxt = 1'b0;
    end else begin
      em_tail_nxt   = em_tail_r >> 8;
      em_tail_n_nxt = em_tail_n_r - TAIL_W'(1);
    end
  end

  assign sts.plan_nonempty = (p_ns_cnt != '0) || (p_pl != '0) || p_sp || (p_tail_n != '0);
  assign sts.out_free      = !out_valid_r || out_chan.ready;
  assign sts.last          = (em_ns_cnt_nxt == '0) && (em_pl_nxt == '0) && !em_sp_nxt &&
                             (em_tail_n_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r  <= 1'b0;
      started_r   <= 1'b0;
      vsp_r       <= 1'b0;
      ns_cnt_r    <= '0;
      ns_kinds_r  <= '0;
      bsp_r       <= 1'b0;
      pl_r        <= '0;
      content_r   <= 1'b0;
      ovf_r       <= 1'b0;
      em_ns_cnt_r <= '0;
      em_pl_r     <= '0;
      em_lf_r     <= 1'b0;
      em_sp_r     <= 1'b0;
      em_tail_n_r <= '0;
    end else if (cmd.load) begin
      in_value_r  <= in_value_nxt;
      started_r   <= started_nxt;
      vsp_r       <= vsp_nxt;
      ns_cnt_r    <= ns_cnt_nxt;
      ns_kinds_r  <= ns_kinds_nxt;
      bsp_r       <= bsp_nxt;
      pl_r        <= pl_nxt;
      content_r   <= content_nxt;
      ovf_r       <= ovf_nxt;
      em_ns_cnt_r <= p_ns_cnt;
      em_pl_r     <= p_pl;
      em_lf_r     <= 1'b0;
      em_sp_r     <= p_sp;
      em_tail_n_r <= p_tail_n;
    end else if (cmd.step) begin
      em_ns_cnt_r <= em_ns_cnt_nxt;
      em_pl_r     <= em_pl_nxt;
      em_lf_r     <= em_lf_nxt;
      em_sp_r     <= em_sp_nxt;
      em_tail_n_r <= em_tail_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      em_kinds_r <= p_ns_kinds;
      em_tail_r  <= p_tail;
      em_ovf_r   <= p_ovf;
    end else if (cmd.step) begin
      em_kinds_r <= em_kinds_nxt;
      em_tail_r  <= em_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                       out_valid_r <= 1'b0;
    else if (cmd.step)                out_valid_r <= 1'b1;
    else if (out_chan.ready)          out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte_r <= em_byte;
      out_last_r <= sts.last;
      out_ovf_r  <= em_ovf_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;
  assign out_chan.overflow = out_ovf_r;

endmodule
